[rtl/xmbr_pkg.sv]
// Shared types and constants for the XMODEM-CRC block receiver.
// No dependencies; imported by xmodem_block_receiver_core.
package xmbr_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] kind_t;

  // Result kinds
  localparam kind_t KindData   = 3'd0;
  localparam kind_t KindCommit = 3'd1;
  localparam kind_t KindDup    = 3'd2;
  localparam kind_t KindNak    = 3'd3;
  localparam kind_t KindAbort  = 3'd4;
  localparam kind_t KindEnd    = 3'd5;

  // Header, reply, pad and inverse-base bytes
  localparam byte_t HdrSoh   = 8'h01;
  localparam byte_t HdrStx   = 8'h02;
  localparam byte_t HdrEot   = 8'h04;
  localparam byte_t ReplyAck = 8'h06;
  localparam byte_t ReplyNak = 8'h15;
  localparam byte_t PadByte  = 8'd26;
  localparam byte_t InverseBase = 8'd255;

  // Block sizes include number, inverse, payload and two CRC bytes
  localparam int SmallBlockTotal = 132;
  localparam int LargeBlockTotal = 1028;
  localparam int CountW = 10;
  localparam logic [CountW-1:0] SmallLastIdx = CountW'(SmallBlockTotal - 4 - 1);
  localparam logic [CountW-1:0] LargeLastIdx = CountW'(LargeBlockTotal - 4 - 1);

  localparam logic [15:0] CrcPoly = 16'h1021;

  // CRC-16/XMODEM, one byte, MSB first
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input byte_t b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/xmodem_block_receiver_core.sv]
// XMODEM-CRC (128/1K) block receiver: header parse, CRC check, verdicts.
// Depends on xmbr_pkg (kinds, header bytes, CRC function).
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+---------------------
//  in      | in_valid_i | in_stall_o | rx_byte_i
//  out     | out_valid_o| out_stall_i| kind_o, out_byte_o
//
// One beat per cycle while the result is not stalled; a byte taken into the input
// register passes through the CRC update and phase logic, and any result it gives
// is captured in the result register. The 8-bit CRC update is combinational.
// Reset puts the receiver in header search with last block number 0.
// A stalled result holds the processing stage, whether or not the waiting byte
// gives a result; the input register then fills and in_stall_o rises.
// After EOT or an abort every byte is dropped until reset.
module xmodem_block_receiver_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  xmbr_pkg::byte_t rx_byte_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output xmbr_pkg::kind_t kind_o,
  output xmbr_pkg::byte_t out_byte_o
);
  import xmbr_pkg::*;

  localparam logic [2:0] PhHeader  = 3'd0;
  localparam logic [2:0] PhNumber  = 3'd1;
  localparam logic [2:0] PhInverse = 3'd2;
  localparam logic [2:0] PhPayload = 3'd3;
  localparam logic [2:0] PhCrcHi   = 3'd4;
  localparam logic [2:0] PhCrcLo   = 3'd5;
  localparam logic [2:0] PhDone    = 3'd6;

  // input register
  logic  in_valid_q;
  byte_t in_byte_q;

  // receiver state
  logic [2:0]        phase_q, phase_d;
  logic              large_q, large_d;
  logic [CountW-1:0] count_q, count_d;
  logic [15:0]       crc_q, crc_d;
  byte_t             number_q, number_d;
  byte_t             inverse_q, inverse_d;
  byte_t             crc_hi_q, crc_hi_d;
  byte_t             last_good_q, last_good_d;
  logic              pad_q, pad_d;

  // result register
  logic  out_valid_q;
  kind_t kind_q;
  byte_t out_byte_q;

  logic  out_free;
  logic  fire;
  logic  res_valid;
  kind_t res_kind;
  byte_t res_byte;
  logic [CountW-1:0] last_idx;
  logic [15:0]       crc_next;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  assign last_idx = large_q ? LargeLastIdx : SmallLastIdx;
  assign crc_next = crc_update(crc_q, in_byte_q);

  always_comb begin
    phase_d     = phase_q;
    large_d     = large_q;
    count_d     = count_q;
    crc_d       = crc_q;
    number_d    = number_q;
    inverse_d   = inverse_q;
    crc_hi_d    = crc_hi_q;
    last_good_d = last_good_q;
    pad_d       = pad_q;
    res_valid   = 1'b0;
    res_kind    = KindData;
    res_byte    = '0;
    case (phase_q)
      PhHeader: begin
        if (in_byte_q == HdrEot) begin
          phase_d   = PhDone;
          res_valid = 1'b1;
          res_kind  = KindEnd;
          res_byte  = ReplyAck;
        end else if (in_byte_q == HdrSoh || in_byte_q == HdrStx) begin
          large_d = (in_byte_q == HdrStx);
          count_d = '0;
          crc_d   = '0;
          pad_d   = 1'b0;
          phase_d = PhNumber;
        end
      end
      PhNumber: begin
        number_d = in_byte_q;
        phase_d  = PhInverse;
      end
      PhInverse: begin
        inverse_d = in_byte_q;
        phase_d   = PhPayload;
      end
      PhPayload: begin
        crc_d = crc_next;
        if (count_q == last_idx) begin
          count_d = '0;
          phase_d = PhCrcHi;
        end else begin
          count_d = count_q + 1'b1;
        end
        if (!pad_q) begin
          if (in_byte_q == PadByte) begin
            pad_d = 1'b1;
          end else begin
            res_valid = 1'b1;
            res_kind  = KindData;
            res_byte  = in_byte_q;
          end
        end
      end
      PhCrcHi: begin
        crc_hi_d = in_byte_q;
        phase_d  = PhCrcLo;
      end
      PhCrcLo: begin
        res_valid = 1'b1;
        if (InverseBase - number_q != inverse_q) begin
          phase_d  = PhDone;
          res_kind = KindAbort;
        end else if (number_q == last_good_q) begin
          phase_d  = PhHeader;
          res_kind = KindDup;
          res_byte = ReplyAck;
        end else if (number_q != last_good_q + 8'd1) begin
          phase_d  = PhDone;
          res_kind = KindAbort;
        end else if (crc_q != {crc_hi_q, in_byte_q}) begin
          phase_d  = PhHeader;
          res_kind = KindNak;
          res_byte = ReplyNak;
        end else begin
          last_good_d = number_q;
          phase_d     = PhHeader;
          res_kind    = KindCommit;
          res_byte    = ReplyAck;
        end
      end
      default: begin
        phase_d = PhDone;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      phase_q     <= PhHeader;
      large_q     <= 1'b0;
      count_q     <= '0;
      crc_q       <= '0;
      number_q    <= '0;
      inverse_q   <= '0;
      crc_hi_q    <= '0;
      last_good_q <= '0;
      pad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire) begin
        phase_q     <= phase_d;
        large_q     <= large_d;
        count_q     <= count_d;
        crc_q       <= crc_d;
        number_q    <= number_d;
        inverse_q   <= inverse_d;
        crc_hi_q    <= crc_hi_d;
        last_good_q <= last_good_d;
        pad_q       <= pad_d;
      end
      if (fire && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
    if (fire && res_valid) begin
      kind_q     <= res_kind;
      out_byte_q <= res_byte;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign out_byte_o  = out_byte_q;

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhDone |=> phase_q == PhDone)
    else $error("left done phase");

  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PhPayload |-> count_q == '0)
    else $error("byte count nonzero outside payload");

  a_no_pad_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindData |-> out_byte_o != PadByte)
    else $error("pad byte emitted as data");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a held result");

  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(phase_q) && $stable(crc_q) && $stable(last_good_q))
    else $error("state moved without a beat");

endmodule
